FILE: sv/cs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cs_pkg
// Shared types, codes and defaults for the Cholesky linear solver core.
// ----------------------------------------------------------------------------
package cs_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_ORDER_DEF  = 16;
   localparam int VALUE_BITS_DEF = 32;

   // Number of fraction bits in every fixed-point value.
   localparam int FRAC_BITS = 16;

   // Row and column fields inside the command struct, wide enough for the
   // largest supported order.
   localparam int IDX_BITS = 6;

   // Fixed widths of the channel fields.
   localparam int OP_BITS   = 2;
   localparam int POS_BITS  = 4;
   localparam int SIZE_BITS = 5;

   // Request operation codes.
   typedef enum logic [OP_BITS-1:0] {
      OP_LOAD_MAT = 2'd0,
      OP_LOAD_RHS = 2'd1,
      OP_SOLVE    = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   // Storage selected by a read or write command.
   typedef enum logic [2:0] {
      MEM_MAT,
      MEM_FAC,
      MEM_RHS,
      MEM_FWD,
      MEM_SOL
   } mem_sel_type;

   // Solve phases: factoring, forward and backward substitution.
   typedef enum logic [1:0] {
      PH_CHOL,
      PH_FWD,
      PH_BWD
   } phase_type;

   // Controller states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_INIT_RD,
      ST_INIT_LD,
      ST_TERM_CHK,
      ST_A_RD,
      ST_B_RD,
      ST_B_LD,
      ST_MUL_WAIT,
      ST_SUB,
      ST_PIVOT,
      ST_DIAG_RD,
      ST_DIAG_LD,
      ST_UNIT_WAIT,
      ST_WRITE,
      ST_OUT_RD,
      ST_OUT_LD,
      ST_FAIL
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                rd_en;
      mem_sel_type         rd_sel;
      logic [IDX_BITS-1:0] rd_row;
      logic [IDX_BITS-1:0] rd_col;
      logic                ld_s;
      logic                ld_a;
      logic                mul_start;
      logic                p_load;
      logic                sub_s;
      logic                dsq_start;
      logic                dsq_sqrt;
      logic                wr_en;
      mem_sel_type         wr_sel;
      logic [IDX_BITS-1:0] wr_row;
      logic [IDX_BITS-1:0] wr_col;
      logic                out_load;
      logic                out_flag;
      logic                out_last;
      logic [POS_BITS-1:0] out_index;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic mul_busy;
      logic dsq_busy;
      logic s_nonpos;
   } status_type;

endpackage
`default_nettype wire

FILE: sv/cs_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cs_if
// Valid/ready channel interfaces: request, response and register write.
// ----------------------------------------------------------------------------

// Request channel: loads and solve commands.
interface cs_req_if #(
   parameter int VALUE_BITS = cs_pkg::VALUE_BITS_DEF
);
   logic                                 valid;
   logic                                 ready;
   logic [cs_pkg::OP_BITS-1:0]           op;
   logic [cs_pkg::POS_BITS-1:0]          row;
   logic [cs_pkg::POS_BITS-1:0]          col;
   logic signed [VALUE_BITS-1:0]         value;

   modport source (output valid, output op, output row, output col, output value,
                   input ready);
   modport sink   (input valid, input op, input row, input col, input value,
                   output ready);
endinterface

// Response channel: solution elements.
interface cs_rsp_if #(
   parameter int VALUE_BITS = cs_pkg::VALUE_BITS_DEF
);
   logic                                 valid;
   logic                                 ready;
   logic [cs_pkg::POS_BITS-1:0]          index;
   logic signed [VALUE_BITS-1:0]         solution;
   logic                                 not_positive_definite;
   logic                                 last;

   modport source (output valid, output index, output solution,
                   output not_positive_definite, output last, input ready);
   modport sink   (input valid, input index, input solution,
                   input not_positive_definite, input last, output ready);
endinterface

// Register write channel: matrix order.
interface cs_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [cs_pkg::SIZE_BITS-1:0]         matrix_size;

   modport source (output valid, output matrix_size, input ready);
   modport sink   (input valid, input matrix_size, output ready);
endinterface
`default_nettype wire

FILE: sv/cs_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cs_mul
// Fixed-point multiplier: sixteen bits of one operand per cycle, saturating.
// ----------------------------------------------------------------------------
module cs_mul #(
   parameter int VALUE_BITS = cs_pkg::VALUE_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic signed [VALUE_BITS-1:0] a,
   input  wire logic signed [VALUE_BITS-1:0] b,
   output logic                              busy,
   output logic signed [VALUE_BITS-1:0]      result
);
   localparam int NCH  = (VALUE_BITS + 15) / 16;
   localparam int BPW  = 16 * NCH;
   localparam int AW   = VALUE_BITS + BPW;
   localparam int SHW  = AW - cs_pkg::FRAC_BITS;
   localparam int CNTW = $clog2(NCH + 1);
   localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

   logic [VALUE_BITS-1:0] am_ff, am_in;
   logic [BPW-1:0]        bm_ff, bm_in;
   logic [AW-1:0]         acc_ff, acc_in;
   logic                  neg_ff, neg_in;
   logic                  busy_ff, busy_in;
   logic [CNTW-1:0]       cnt_ff, cnt_in;
   logic [VALUE_BITS+15:0] pp;
   logic [SHW-1:0]        sh;
   logic [VALUE_BITS-1:0] a_mag, b_mag;

   // Operand magnitudes; the most negative value maps to its true magnitude.
   assign a_mag = a[VALUE_BITS-1] ? (~a + 1'b1) : a;
   assign b_mag = b[VALUE_BITS-1] ? (~b + 1'b1) : b;

   // One partial product per cycle, most significant chunk first.
   assign pp = am_ff * bm_ff[BPW-1 -: 16];

   always_comb begin
      am_in   = am_ff;
      bm_in   = bm_ff;
      acc_in  = acc_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         am_in   = a_mag;
         bm_in   = BPW'(b_mag);
         acc_in  = '0;
         neg_in  = a[VALUE_BITS-1] ^ b[VALUE_BITS-1];
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         acc_in = {acc_ff[AW-17:0], 16'b0} + AW'(pp);
         bm_in  = {bm_ff[BPW-17:0], 16'b0};
         cnt_in = CNTW'(cnt_ff + 1'b1);
         if (cnt_ff == CNTW'(NCH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      am_ff  <= am_in;
      bm_ff  <= bm_in;
      acc_ff <= acc_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   // Drop the fraction bits and saturate to the value range.
   assign sh = acc_ff[AW-1:cs_pkg::FRAC_BITS];

   always_comb begin
      if (sh > SHW'(VMAX)) begin
         result = neg_ff ? VMIN : VMAX;
      end else if (neg_ff) begin
         result = ~sh[VALUE_BITS-1:0] + 1'b1;
      end else begin
         result = sh[VALUE_BITS-1:0];
      end
   end

   assign busy = busy_ff;

endmodule
`default_nettype wire

FILE: sv/cs_dsq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cs_dsq
// Shared fixed-point divider and square root, one quotient or root bit per
// cycle, with saturation of the result.
// ----------------------------------------------------------------------------
module cs_dsq #(
   parameter int VALUE_BITS = cs_pkg::VALUE_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic                         sqrt_mode,
   input  wire logic signed [VALUE_BITS-1:0] num,
   input  wire logic signed [VALUE_BITS-1:0] den,
   output logic                              busy,
   output logic signed [VALUE_BITS-1:0]      result
);
   localparam int P    = (VALUE_BITS + cs_pkg::FRAC_BITS + 1) / 2;
   localparam int SW   = 2 * P;
   localparam int RW   = VALUE_BITS + 3;
   localparam int CNTW = $clog2(SW + 1);
   localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

   logic [SW-1:0]         src_ff, src_in;
   logic [RW-1:0]         rem_ff, rem_in;
   logic [SW-1:0]         q_ff, q_in;
   logic [VALUE_BITS-1:0] dm_ff, dm_in;
   logic                  sq_ff, sq_in;
   logic                  neg_ff, neg_in;
   logic                  dz_ff, dz_in;
   logic                  busy_ff, busy_in;
   logic [CNTW-1:0]       cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] n_mag, d_mag;
   logic [RW-1:0]         r2, t, sub;
   logic                  ge;

   assign n_mag = num[VALUE_BITS-1] ? (~num + 1'b1) : num;
   assign d_mag = den[VALUE_BITS-1] ? (~den + 1'b1) : den;

   // Trial subtract for one division bit or one root bit.
   always_comb begin
      if (sq_ff) begin
         r2 = {rem_ff[RW-3:0], src_ff[SW-1:SW-2]};
         t  = RW'({q_ff[P-1:0], 2'b01});
      end else begin
         r2 = {rem_ff[RW-2:0], src_ff[SW-1]};
         t  = RW'(dm_ff);
      end
      ge  = (r2 >= t);
      sub = r2 - t;
   end

   always_comb begin
      src_in  = src_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      dm_in   = dm_ff;
      sq_in   = sq_ff;
      neg_in  = neg_ff;
      dz_in   = dz_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         src_in  = SW'({n_mag, {cs_pkg::FRAC_BITS{1'b0}}});
         rem_in  = '0;
         q_in    = '0;
         dm_in   = d_mag;
         sq_in   = sqrt_mode;
         dz_in   = !sqrt_mode && (den == '0);
         neg_in  = sqrt_mode ? 1'b0
                 : (den == '0) ? num[VALUE_BITS-1]
                 : (num[VALUE_BITS-1] ^ den[VALUE_BITS-1]);
         busy_in = sqrt_mode || (den != '0);
         cnt_in  = sqrt_mode ? CNTW'(P) : CNTW'(SW);
      end else if (busy_ff) begin
         rem_in = ge ? sub : r2;
         q_in   = {q_ff[SW-2:0], ge};
         src_in = sq_ff ? {src_ff[SW-3:0], 2'b00} : {src_ff[SW-2:0], 1'b0};
         cnt_in = CNTW'(cnt_ff - 1'b1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      src_ff <= src_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      dm_ff  <= dm_in;
      sq_ff  <= sq_in;
      neg_ff <= neg_in;
      dz_ff  <= dz_in;
      cnt_ff <= cnt_in;
   end

   // Saturate the magnitude; a zero divisor gives the extreme of the
   // dividend's sign.
   always_comb begin
      if (dz_ff || (q_ff > SW'(VMAX))) begin
         result = neg_ff ? VMIN : VMAX;
      end else if (neg_ff) begin
         result = ~q_ff[VALUE_BITS-1:0] + 1'b1;
      end else begin
         result = q_ff[VALUE_BITS-1:0];
      end
   end

   assign busy = busy_ff;

endmodule
`default_nettype wire

FILE: sv/cs_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cs_dpath
// Solver datapath: matrix, factor and vector storage, the accumulator, the
// arithmetic units and the response payload register.
// ----------------------------------------------------------------------------
module cs_dpath #(
   parameter int MAX_ORDER  = cs_pkg::MAX_ORDER_DEF,
   parameter int VALUE_BITS = cs_pkg::VALUE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire cs_pkg::cmd_type                   cmd,
   output cs_pkg::status_type                     status,
   input  wire logic                              load_accept,
   input  wire logic [cs_pkg::OP_BITS-1:0]        load_op,
   input  wire logic [cs_pkg::POS_BITS-1:0]       load_row,
   input  wire logic [cs_pkg::POS_BITS-1:0]       load_col,
   input  wire logic signed [VALUE_BITS-1:0]      load_value,
   output logic [cs_pkg::POS_BITS-1:0]            out_index,
   output logic signed [VALUE_BITS-1:0]           out_solution,
   output logic                                   out_flag,
   output logic                                   out_last
);
   localparam int IW = $clog2(MAX_ORDER);

   logic signed [VALUE_BITS-1:0] mat_mem [MAX_ORDER][MAX_ORDER];
   logic signed [VALUE_BITS-1:0] fac_mem [MAX_ORDER][MAX_ORDER];
   logic signed [VALUE_BITS-1:0] rhs_mem [MAX_ORDER];
   logic signed [VALUE_BITS-1:0] fwd_mem [MAX_ORDER];
   logic signed [VALUE_BITS-1:0] sol_mem [MAX_ORDER];

   logic signed [VALUE_BITS-1:0] rdata_ff;
   logic signed [VALUE_BITS-1:0] s_ff, s_in;
   logic signed [VALUE_BITS-1:0] a_ff;
   logic signed [VALUE_BITS-1:0] p_ff;
   logic [cs_pkg::POS_BITS-1:0]  idx_ff;
   logic signed [VALUE_BITS-1:0] sol_ff;
   logic                         flag_ff;
   logic                         last_ff;

   logic [cs_pkg::POS_BITS-1:0]  hi, lo;
   logic [IW-1:0]                hi_idx, lo_idx, row_idx;
   logic                         mat_we, rhs_we;
   logic [IW-1:0]                rd_r, rd_c, wr_r, wr_c;
   logic signed [VALUE_BITS-1:0] mul_res, dsq_res;
   logic                         mul_busy, dsq_busy;
   logic [VALUE_BITS:0]          diff;

   // Load decoding: an upper-triangle entry lands on its mirror.
   assign hi      = (load_row >= load_col) ? load_row : load_col;
   assign lo      = (load_row >= load_col) ? load_col : load_row;
   assign hi_idx  = IW'(hi);
   assign lo_idx  = IW'(lo);
   assign row_idx = IW'(load_row);
   assign mat_we  = load_accept && (load_op == cs_pkg::OP_LOAD_MAT)
                    && (32'(hi) < MAX_ORDER);
   assign rhs_we  = load_accept && (load_op == cs_pkg::OP_LOAD_RHS)
                    && (32'(load_row) < MAX_ORDER);

   assign rd_r = cmd.rd_row[IW-1:0];
   assign rd_c = cmd.rd_col[IW-1:0];
   assign wr_r = cmd.wr_row[IW-1:0];
   assign wr_c = cmd.wr_col[IW-1:0];

   // Storage written by load transactions.
   always_ff @(posedge clock) begin
      if (mat_we) begin
         mat_mem[hi_idx][lo_idx] <= load_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rhs_we) begin
         rhs_mem[row_idx] <= load_value;
      end
   end

   // Storage written by the solve sequence.
   always_ff @(posedge clock) begin
      if (cmd.wr_en && (cmd.wr_sel == cs_pkg::MEM_FAC)) begin
         fac_mem[wr_r][wr_c] <= dsq_res;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && (cmd.wr_sel == cs_pkg::MEM_FWD)) begin
         fwd_mem[wr_r] <= dsq_res;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && (cmd.wr_sel == cs_pkg::MEM_SOL)) begin
         sol_mem[wr_r] <= dsq_res;
      end
   end

   // Single registered read port over all storage.
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         unique case (cmd.rd_sel)
            cs_pkg::MEM_MAT: rdata_ff <= mat_mem[rd_r][rd_c];
            cs_pkg::MEM_FAC: rdata_ff <= fac_mem[rd_r][rd_c];
            cs_pkg::MEM_RHS: rdata_ff <= rhs_mem[rd_r];
            cs_pkg::MEM_FWD: rdata_ff <= fwd_mem[rd_r];
            cs_pkg::MEM_SOL: rdata_ff <= sol_mem[rd_r];
            default:         rdata_ff <= rdata_ff;
         endcase
      end
   end

   // Saturating subtract of the registered product from the accumulator.
   assign diff = {s_ff[VALUE_BITS-1], s_ff} - {p_ff[VALUE_BITS-1], p_ff};

   always_comb begin
      s_in = s_ff;
      if (cmd.ld_s) begin
         s_in = rdata_ff;
      end else if (cmd.sub_s) begin
         if (diff[VALUE_BITS] != diff[VALUE_BITS-1]) begin
            s_in = diff[VALUE_BITS] ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                                    : {1'b0, {(VALUE_BITS-1){1'b1}}};
         end else begin
            s_in = diff[VALUE_BITS-1:0];
         end
      end
   end

   // Working registers and the response payload.
   always_ff @(posedge clock) begin
      s_ff <= s_in;
      if (cmd.ld_a) begin
         a_ff <= rdata_ff;
      end
      if (cmd.p_load) begin
         p_ff <= mul_res;
      end
      if (cmd.out_load) begin
         idx_ff  <= cmd.out_index;
         sol_ff  <= cmd.out_flag ? '0 : rdata_ff;
         flag_ff <= cmd.out_flag;
         last_ff <= cmd.out_last;
      end
   end

   cs_mul #(
      .VALUE_BITS (VALUE_BITS)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .a      (a_ff),
      .b      (rdata_ff),
      .busy   (mul_busy),
      .result (mul_res)
   );

   cs_dsq #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dsq (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.dsq_start),
      .sqrt_mode (cmd.dsq_sqrt),
      .num       (s_ff),
      .den       (rdata_ff),
      .busy      (dsq_busy),
      .result    (dsq_res)
   );

   assign status.mul_busy = mul_busy;
   assign status.dsq_busy = dsq_busy;
   assign status.s_nonpos = s_ff[VALUE_BITS-1] || (s_ff == '0);

   assign out_index    = idx_ff;
   assign out_solution = sol_ff;
   assign out_flag     = flag_ff;
   assign out_last     = last_ff;

endmodule
`default_nettype wire

FILE: sv/cs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cs_ctrl
// Solver sequencer: walks the factoring, forward and backward substitution
// loops, issues datapath commands and runs the channel handshakes.
// ----------------------------------------------------------------------------
module cs_ctrl #(
   parameter int MAX_ORDER = cs_pkg::MAX_ORDER_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic [cs_pkg::OP_BITS-1:0]    req_op,
   output logic                               req_ready,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic                          csr_valid,
   input  wire logic [cs_pkg::SIZE_BITS-1:0]  csr_matrix_size,
   output logic                               csr_ready,
   output cs_pkg::cmd_type                    cmd,
   input  wire cs_pkg::status_type            status
);
   localparam int CW = $clog2(MAX_ORDER + 1);

   cs_pkg::state_type            state_ff, state_in;
   cs_pkg::phase_type            phase_ff, phase_in;
   logic [CW-1:0]                i_ff, i_in;
   logic [CW-1:0]                j_ff, j_in;
   logic [CW-1:0]                k_ff, k_in;
   logic [cs_pkg::SIZE_BITS-1:0] size_ff;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0] n_eff, i_inc, j_inc, k_inc, diag;
   logic          terms_done, out_free, is_last;

   // Active order, clamped to the supported range.
   always_comb begin
      if (size_ff == '0) begin
         n_eff = CW'(1);
      end else if (32'(size_ff) > MAX_ORDER) begin
         n_eff = CW'(MAX_ORDER);
      end else begin
         n_eff = CW'(size_ff);
      end
   end

   assign i_inc    = CW'(i_ff + 1'b1);
   assign j_inc    = CW'(j_ff + 1'b1);
   assign k_inc    = CW'(k_ff + 1'b1);
   assign diag     = (phase_ff == cs_pkg::PH_CHOL) ? j_ff : i_ff;
   assign is_last  = (i_inc == n_eff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // End of the inner product loop for the current phase.
   always_comb begin
      unique case (phase_ff)
         cs_pkg::PH_CHOL: terms_done = (k_ff == j_ff);
         cs_pkg::PH_FWD:  terms_done = (k_ff == i_ff);
         cs_pkg::PH_BWD:  terms_done = (k_ff == n_eff);
         default:         terms_done = 1'b1;
      endcase
   end

   // Next state and loop counters.
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      unique case (state_ff)
         cs_pkg::ST_IDLE: begin
            if (req_valid && (req_op == cs_pkg::OP_SOLVE)) begin
               phase_in = cs_pkg::PH_CHOL;
               i_in     = '0;
               j_in     = '0;
               state_in = cs_pkg::ST_INIT_RD;
            end
         end
         cs_pkg::ST_INIT_RD: state_in = cs_pkg::ST_INIT_LD;
         cs_pkg::ST_INIT_LD: begin
            k_in     = (phase_ff == cs_pkg::PH_BWD) ? i_inc : '0;
            state_in = cs_pkg::ST_TERM_CHK;
         end
         cs_pkg::ST_TERM_CHK: begin
            state_in = terms_done ? cs_pkg::ST_PIVOT : cs_pkg::ST_A_RD;
         end
         cs_pkg::ST_A_RD: state_in = cs_pkg::ST_B_RD;
         cs_pkg::ST_B_RD: state_in = cs_pkg::ST_B_LD;
         cs_pkg::ST_B_LD: state_in = cs_pkg::ST_MUL_WAIT;
         cs_pkg::ST_MUL_WAIT: begin
            if (!status.mul_busy) begin
               state_in = cs_pkg::ST_SUB;
            end
         end
         cs_pkg::ST_SUB: begin
            k_in     = k_inc;
            state_in = cs_pkg::ST_TERM_CHK;
         end
         cs_pkg::ST_PIVOT: begin
            if ((phase_ff == cs_pkg::PH_CHOL) && (i_ff == j_ff)) begin
               state_in = status.s_nonpos ? cs_pkg::ST_FAIL : cs_pkg::ST_UNIT_WAIT;
            end else begin
               state_in = cs_pkg::ST_DIAG_RD;
            end
         end
         cs_pkg::ST_DIAG_RD: state_in = cs_pkg::ST_DIAG_LD;
         cs_pkg::ST_DIAG_LD: state_in = cs_pkg::ST_UNIT_WAIT;
         cs_pkg::ST_UNIT_WAIT: begin
            if (!status.dsq_busy) begin
               state_in = cs_pkg::ST_WRITE;
            end
         end
         cs_pkg::ST_WRITE: begin
            state_in = cs_pkg::ST_INIT_RD;
            unique case (phase_ff)
               cs_pkg::PH_CHOL: begin
                  if (j_ff != i_ff) begin
                     j_in = j_inc;
                  end else if (is_last) begin
                     phase_in = cs_pkg::PH_FWD;
                     i_in     = '0;
                  end else begin
                     i_in = i_inc;
                     j_in = '0;
                  end
               end
               cs_pkg::PH_FWD: begin
                  if (is_last) begin
                     phase_in = cs_pkg::PH_BWD;
                  end else begin
                     i_in = i_inc;
                  end
               end
               default: begin
                  if (i_ff == '0) begin
                     state_in = cs_pkg::ST_OUT_RD;
                  end else begin
                     i_in = CW'(i_ff - 1'b1);
                  end
               end
            endcase
         end
         cs_pkg::ST_OUT_RD: state_in = cs_pkg::ST_OUT_LD;
         cs_pkg::ST_OUT_LD: begin
            if (out_free) begin
               if (is_last) begin
                  state_in = cs_pkg::ST_IDLE;
               end else begin
                  i_in     = i_inc;
                  state_in = cs_pkg::ST_OUT_RD;
               end
            end
         end
         cs_pkg::ST_FAIL: begin
            if (out_free) begin
               state_in = cs_pkg::ST_IDLE;
            end
         end
         default: state_in = cs_pkg::ST_IDLE;
      endcase
   end

   // Datapath commands for each state.
   always_comb begin
      cmd           = '0;
      cmd.out_index = cs_pkg::POS_BITS'(i_ff);
      unique case (state_ff)
         cs_pkg::ST_INIT_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_row = cs_pkg::IDX_BITS'(i_ff);
            cmd.rd_col = cs_pkg::IDX_BITS'(j_ff);
            unique case (phase_ff)
               cs_pkg::PH_CHOL: cmd.rd_sel = cs_pkg::MEM_MAT;
               cs_pkg::PH_FWD:  cmd.rd_sel = cs_pkg::MEM_RHS;
               default:         cmd.rd_sel = cs_pkg::MEM_FWD;
            endcase
         end
         cs_pkg::ST_INIT_LD: cmd.ld_s = 1'b1;
         cs_pkg::ST_A_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = cs_pkg::MEM_FAC;
            if (phase_ff == cs_pkg::PH_BWD) begin
               cmd.rd_row = cs_pkg::IDX_BITS'(k_ff);
               cmd.rd_col = cs_pkg::IDX_BITS'(i_ff);
            end else begin
               cmd.rd_row = cs_pkg::IDX_BITS'(i_ff);
               cmd.rd_col = cs_pkg::IDX_BITS'(k_ff);
            end
         end
         cs_pkg::ST_B_RD: begin
            cmd.ld_a   = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_col = cs_pkg::IDX_BITS'(k_ff);
            unique case (phase_ff)
               cs_pkg::PH_CHOL: begin
                  cmd.rd_sel = cs_pkg::MEM_FAC;
                  cmd.rd_row = cs_pkg::IDX_BITS'(j_ff);
               end
               cs_pkg::PH_FWD: begin
                  cmd.rd_sel = cs_pkg::MEM_FWD;
                  cmd.rd_row = cs_pkg::IDX_BITS'(k_ff);
               end
               default: begin
                  cmd.rd_sel = cs_pkg::MEM_SOL;
                  cmd.rd_row = cs_pkg::IDX_BITS'(k_ff);
               end
            endcase
         end
         cs_pkg::ST_B_LD:     cmd.mul_start = 1'b1;
         cs_pkg::ST_MUL_WAIT: cmd.p_load    = !status.mul_busy;
         cs_pkg::ST_SUB:      cmd.sub_s     = 1'b1;
         cs_pkg::ST_PIVOT: begin
            cmd.dsq_sqrt  = 1'b1;
            cmd.dsq_start = (phase_ff == cs_pkg::PH_CHOL) && (i_ff == j_ff)
                            && !status.s_nonpos;
         end
         cs_pkg::ST_DIAG_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = cs_pkg::MEM_FAC;
            cmd.rd_row = cs_pkg::IDX_BITS'(diag);
            cmd.rd_col = cs_pkg::IDX_BITS'(diag);
         end
         cs_pkg::ST_DIAG_LD: cmd.dsq_start = 1'b1;
         cs_pkg::ST_WRITE: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_row = cs_pkg::IDX_BITS'(i_ff);
            cmd.wr_col = cs_pkg::IDX_BITS'(j_ff);
            unique case (phase_ff)
               cs_pkg::PH_CHOL: cmd.wr_sel = cs_pkg::MEM_FAC;
               cs_pkg::PH_FWD:  cmd.wr_sel = cs_pkg::MEM_FWD;
               default:         cmd.wr_sel = cs_pkg::MEM_SOL;
            endcase
         end
         cs_pkg::ST_OUT_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = cs_pkg::MEM_SOL;
            cmd.rd_row = cs_pkg::IDX_BITS'(i_ff);
         end
         cs_pkg::ST_OUT_LD: begin
            cmd.out_load = out_free;
            cmd.out_last = is_last;
         end
         cs_pkg::ST_FAIL: begin
            cmd.out_load = out_free;
            cmd.out_flag = 1'b1;
            cmd.out_last = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Response valid holds until the transaction completes.
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cs_pkg::ST_IDLE;
         phase_ff     <= cs_pkg::PH_CHOL;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         size_ff      <= cs_pkg::SIZE_BITS'(16);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            size_ff <= csr_matrix_size;
         end
      end
   end

   assign req_ready = (state_ff == cs_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = 1'b1;

endmodule
`default_nettype wire

FILE: sv/cholesky_spd_solver_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cholesky_spd_solver_core
// Solves A x = b for a symmetric positive definite matrix in signed
// fixed point, by Cholesky factoring and two triangular substitutions.
// ----------------------------------------------------------------------------
//  channel  direction  transaction
//  req      in         load matrix entry, load right-hand side, or solve
//  rsp      out        one solution element, or one not-positive-definite flag
//  csr      in         write matrix order (always ready)
//
// A solve runs on one shared sequential multiplier and one shared
// bit-serial divide/square-root unit; for order n this is roughly n^3/6
// products and n^2/2 + 2n divides. Requests are held off for the whole
// solve; the last response may still wait in its register while new loads
// are taken.
// Reset is synchronous and active high; stored matrix data is not cleared.
// ----------------------------------------------------------------------------
module cholesky_spd_solver_core #(
   parameter int MAX_ORDER  = cs_pkg::MAX_ORDER_DEF,
   parameter int VALUE_BITS = cs_pkg::VALUE_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   cs_req_if.sink   req,
   cs_rsp_if.source rsp,
   cs_csr_if.sink   csr
);
   cs_pkg::cmd_type    cmd;
   cs_pkg::status_type status;
   logic               req_ready;

   assign req.ready = req_ready;

   cs_ctrl #(
      .MAX_ORDER (MAX_ORDER)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req.valid),
      .req_op          (req.op),
      .req_ready       (req_ready),
      .rsp_valid       (rsp.valid),
      .rsp_ready       (rsp.ready),
      .csr_valid       (csr.valid),
      .csr_matrix_size (csr.matrix_size),
      .csr_ready       (csr.ready),
      .cmd             (cmd),
      .status          (status)
   );

   cs_dpath #(
      .MAX_ORDER  (MAX_ORDER),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .load_accept  (req.valid && req_ready),
      .load_op      (req.op),
      .load_row     (req.row),
      .load_col     (req.col),
      .load_value   (req.value),
      .out_index    (rsp.index),
      .out_solution (rsp.solution),
      .out_flag     (rsp.not_positive_definite),
      .out_last     (rsp.last)
   );

`ifndef ASSERT_OFF
   // A product is never started while the divide/root unit is running.
   assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |-> !status.dsq_busy)
      else $error("multiply started during divide or root");

   // Results are written back only after both units are idle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (!status.dsq_busy && !status.mul_busy))
      else $error("write-back while an arithmetic unit is busy");

   // The multiplier only becomes busy on a start command.
   assert property (@(posedge clock) disable iff (reset)
      $rose(status.mul_busy) |-> $past(cmd.mul_start))
      else $error("multiplier busy without a start");
`endif

endmodule
`default_nettype wire

FILE: dv/tb_cholesky_spd_solver_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cholesky_spd_solver_core
// Drives matrix and right-hand-side loads and solve commands into the
// Cholesky solver core with random idling on both channels, predicts every
// solution element in fixed point, and compares each response in order.
// ----------------------------------------------------------------------------
module tb_cholesky_spd_solver_core;

   localparam int ORD = 16;
   localparam int VB = 32;
   localparam int WATCHDOG_LIMIT = 200000;

   localparam logic signed [63:0] VMAX = 64'sd2147483647;
   localparam logic signed [63:0] VMIN = -64'sd2147483648;

   typedef struct packed {
      logic [cs_pkg::POS_BITS-1:0] index;
      logic [VB-1:0]               solution;
      logic                        npd;
      logic                        last;
   } elem_type;

   typedef struct {
      cs_pkg::op_type op;
      int             row;
      int             col;
      logic [31:0]    value;
      int             size;     // order written before this row, or -1
      int             fixed;    // 1 when the expected response is typed in
      elem_type       ans;
   } row_type;

   logic clock;
   logic reset;
   cs_req_if #(.VALUE_BITS(VB)) req ();
   cs_rsp_if #(.VALUE_BITS(VB)) rsp ();
   cs_csr_if csr ();

   cholesky_spd_solver_core #(.MAX_ORDER(ORD), .VALUE_BITS(VB)) u_top (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   // Predictor state.
   logic signed [63:0] mat_m [ORD][ORD];
   logic signed [63:0] fac_m [ORD][ORD];
   logic signed [63:0] rhs_m [ORD];
   logic signed [63:0] fwd_m [ORD];
   logic signed [63:0] sol_m [ORD];
   int                 order_m;

   elem_type expected_q[$];
   int       errors;
   int       watchdog;
   int       rsp_stall;

   // Bookkeeping of written entries, recorded on each load but never checked.
   bit    mat_wr [ORD][ORD];
   bit    rhs_wr [ORD];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [63:0] sat(logic signed [127:0] v);
      if (v > VMAX) return VMAX;
      if (v < VMIN) return VMIN;
      return v[63:0];
   endfunction

   function automatic logic signed [63:0] mul_q(logic signed [63:0] a,
                                                logic signed [63:0] b);
      logic [127:0] ma;
      logic [127:0] mb;
      logic [127:0] p;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      p = (ma * mb) >> cs_pkg::FRAC_BITS;
      if ((a < 0) != (b < 0)) return sat(-$signed(p));
      return sat($signed(p));
   endfunction

   function automatic logic signed [63:0] div_q(logic signed [63:0] n,
                                                logic signed [63:0] d);
      logic [127:0] mn;
      logic [127:0] md;
      logic [127:0] q;
      if (d == 0) return n < 0 ? VMIN : VMAX;
      mn = n < 0 ? -n : n;
      md = d < 0 ? -d : d;
      q = (mn << cs_pkg::FRAC_BITS) / md;
      if ((n < 0) != (d < 0)) return sat(-$signed(q));
      return sat($signed(q));
   endfunction

   function automatic logic signed [63:0] sqrt_q(logic signed [63:0] s);
      logic [127:0] v;
      logic [127:0] r;
      logic [127:0] t;
      logic [127:0] root;
      v = s << cs_pkg::FRAC_BITS;
      r = 0;
      root = 0;
      for (int p = 39; p >= 0; p--) begin
         r = (r << 2) | ((v >> (2 * p)) & 3);
         t = (root << 2) | 1;
         if (r >= t) begin
            r = r - t;
            root = (root << 1) | 1;
         end else begin
            root = root << 1;
         end
      end
      return sat($signed(root));
   endfunction

   function automatic logic signed [63:0] sub_q(logic signed [63:0] a,
                                                logic signed [63:0] b);
      return sat(128'(a) - 128'(b));
   endfunction

   // Apply one request to the predictor, queueing the responses it causes.
   task automatic predict_request(cs_pkg::op_type op, int row, int col,
                                  logic [31:0] value);
      logic signed [63:0] v;
      logic signed [63:0] s;
      int n;
      int hi;
      int lo;
      elem_type e;
      v = 64'($signed(value));
      if (op == cs_pkg::OP_LOAD_MAT) begin
         hi = row >= col ? row : col;
         lo = row >= col ? col : row;
         mat_m[hi][lo] = v;
         mat_wr[hi][lo] = 1'b1;
         return;
      end
      if (op == cs_pkg::OP_LOAD_RHS) begin
         rhs_m[row] = v;
         rhs_wr[row] = 1'b1;
         return;
      end
      if (op != cs_pkg::OP_SOLVE) return;
      n = order_m < 1 ? 1 : (order_m > ORD ? ORD : order_m);
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j <= i; j++) begin
            s = mat_m[i][j];
            for (int k = 0; k < j; k++) s = sub_q(s, mul_q(fac_m[i][k], fac_m[j][k]));
            if (i == j) begin
               if (s <= 0) begin
                  e.index = cs_pkg::POS_BITS'(i);
                  e.solution = '0;
                  e.npd = 1'b1;
                  e.last = 1'b1;
                  expected_q.push_back(e);
                  return;
               end
               fac_m[i][i] = sqrt_q(s);
            end else begin
               fac_m[i][j] = div_q(s, fac_m[j][j]);
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         s = rhs_m[i];
         for (int k = 0; k < i; k++) s = sub_q(s, mul_q(fac_m[i][k], fwd_m[k]));
         fwd_m[i] = div_q(s, fac_m[i][i]);
      end
      for (int i = n - 1; i >= 0; i--) begin
         s = fwd_m[i];
         for (int k = i + 1; k < n; k++) s = sub_q(s, mul_q(fac_m[k][i], sol_m[k]));
         sol_m[i] = div_q(s, fac_m[i][i]);
      end
      for (int i = 0; i < n; i++) begin
         e.index = cs_pkg::POS_BITS'(i);
         e.solution = sol_m[i][31:0];
         e.npd = 1'b0;
         e.last = (i == n - 1);
         expected_q.push_back(e);
      end
   endtask

   task automatic report_mismatch(string what, elem_type got, elem_type want);
      $display("mismatch %s: got idx %0d x %h npd %b last %b, want idx %0d x %h npd %b last %b",
               what, got.index, got.solution, got.npd, got.last,
               want.index, want.solution, want.npd, want.last);
      errors++;
   endtask

   // Response side: random stall, compare each accepted transaction.
   initial begin
      rsp.ready = 1'b0;
      rsp_stall = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp.valid && rsp.ready) begin
            elem_type got;
            got.index = rsp.index;
            got.solution = rsp.solution;
            got.npd = rsp.not_positive_definite;
            got.last = rsp.last;
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected", got, got);
            end else begin
               elem_type want;
               want = expected_q.pop_front();
               if (got !== want) report_mismatch("field", got, want);
            end
            rsp_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         end
         if (rsp_stall > 0) begin
            rsp.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any accepted transaction.
   initial begin
      watchdog = 0;
      forever begin
         @(posedge clock);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)
             || (csr.valid && csr.ready))
            watchdog = 0;
         else
            watchdog++;
         if (watchdog >= WATCHDOG_LIMIT) begin
            $display("tb_cholesky_spd_solver_core failed");
            $finish;
         end
      end
   end

   // Request valid drops only when a gap follows, so a back-to-back
   // transaction sees a single assignment of valid in its time step.
   task automatic idle_cycles();
      int w;
      w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
      if (w > 0) req.valid <= 1'b0;
      repeat (w) @(posedge clock);
   endtask

   task automatic send_request(cs_pkg::op_type op, int row, int col, logic [31:0] value);
      req.valid <= 1'b1;
      req.op <= op;
      req.row <= cs_pkg::POS_BITS'(row);
      req.col <= cs_pkg::POS_BITS'(col);
      req.value <= value;
      do @(posedge clock); while (!req.ready);
      predict_request(op, row, col, value);
   endtask

   // Wait until idle, then write the matrix order.
   task automatic write_order(int n);
      req.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      csr.valid <= 1'b1;
      csr.matrix_size <= cs_pkg::SIZE_BITS'(n);
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      order_m = n & 31;
   endtask

   // Load a random system of order n, mostly a diagonally dominant SPD one, then solve.
   task automatic random_system(int n);
      int dom;
      dom = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j <= i; j++) begin
            logic [31:0] v;
            if (i == j)
               v = (dom == 0) ? $urandom() : (n + 1 + $urandom_range(0, 8)) << 16;
            else
               v = (dom == 0) ? $urandom() : $signed($urandom_range(0, 131072)) - 65536;
            if ($urandom_range(0, 1)) send_request(cs_pkg::OP_LOAD_MAT, i, j, v);
            else send_request(cs_pkg::OP_LOAD_MAT, j, i, v);
            idle_cycles();
         end
         send_request(cs_pkg::OP_LOAD_RHS, i, $urandom_range(0, 15),
                      (dom == 1) ? $urandom() : $signed($urandom_range(0, 1 << 20)) - (1 << 19));
         idle_cycles();
      end
      if ($urandom_range(0, 4) == 0) send_request(cs_pkg::OP_NONE, $urandom_range(0, 15),
                                                  $urandom_range(0, 15), $urandom());
      send_request(cs_pkg::OP_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom());
      idle_cycles();
   endtask

   row_type tbl[$];
   int      items;

   task automatic add_row(cs_pkg::op_type op, int row, int col, logic [31:0] value,
                          int size, int fixed, elem_type ans);
      row_type r;
      r.op = op;
      r.row = row;
      r.col = col;
      r.value = value;
      r.size = size;
      r.fixed = fixed;
      r.ans = ans;
      tbl.push_back(r);
   endtask

   initial begin
      elem_type none;
      elem_type npd0;
      none = '0;
      npd0 = '{index: 0, solution: '0, npd: 1'b1, last: 1'b1};
      errors = 0;
      order_m = 16;
      for (int i = 0; i < ORD; i++) begin
         for (int j = 0; j < ORD; j++) begin
            mat_m[i][j] = 0;
            fac_m[i][j] = 0;
            mat_wr[i][j] = 0;
         end
         rhs_m[i] = 0;
         fwd_m[i] = 0;
         sol_m[i] = 0;
         rhs_wr[i] = 0;
      end
      reset = 1'b1;
      req.valid = 1'b0;
      req.op = cs_pkg::OP_LOAD_MAT;
      req.row = '0;
      req.col = '0;
      req.value = '0;
      csr.valid = 1'b0;
      csr.matrix_size = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: order 1 extremes, zero and negative pivots,
      // mirrored upper load, unused op and order 0.
      add_row(cs_pkg::OP_LOAD_MAT, 0, 0, 32'h0000_0000, 1, 0, none);
      add_row(cs_pkg::OP_LOAD_RHS, 0, 0, 32'h7FFF_FFFF, -1, 0, none);
      add_row(cs_pkg::OP_SOLVE, 0, 0, 0, -1, 1, npd0);
      add_row(cs_pkg::OP_LOAD_MAT, 0, 0, 32'h8000_0000, -1, 0, none);
      add_row(cs_pkg::OP_SOLVE, 15, 15, 32'hFFFF_FFFF, -1, 1, npd0);
      add_row(cs_pkg::OP_LOAD_MAT, 0, 0, 32'h0001_0000, -1, 0, none);
      add_row(cs_pkg::OP_SOLVE, 0, 0, 0, -1, 1,
              '{index: 0, solution: 32'h7FFF_FFFF, npd: 1'b0, last: 1'b1});
      add_row(cs_pkg::OP_LOAD_RHS, 0, 0, 32'h8000_0000, -1, 0, none);
      add_row(cs_pkg::OP_SOLVE, 0, 0, 0, -1, 1,
              '{index: 0, solution: 32'h8000_0000, npd: 1'b0, last: 1'b1});
      add_row(cs_pkg::OP_LOAD_MAT, 0, 0, 32'h7FFF_FFFF, -1, 0, none);
      add_row(cs_pkg::OP_NONE, 15, 0, 32'h5555_AAAA, -1, 0, none);
      add_row(cs_pkg::OP_SOLVE, 0, 0, 0, 0, 0, none);
      add_row(cs_pkg::OP_LOAD_MAT, 1, 1, 32'h0004_0000, 2, 0, none);
      add_row(cs_pkg::OP_LOAD_MAT, 0, 1, 32'hFFFF_0000, -1, 0, none);
      add_row(cs_pkg::OP_LOAD_RHS, 1, 15, 32'h0002_0000, -1, 0, none);
      add_row(cs_pkg::OP_SOLVE, 0, 0, 0, -1, 0, none);
      add_row(cs_pkg::OP_LOAD_MAT, 1, 1, 32'h0000_0001, -1, 0, none);
      add_row(cs_pkg::OP_SOLVE, 0, 0, 0, -1, 1,
              '{index: 1, solution: '0, npd: 1'b1, last: 1'b1});

      foreach (tbl[t]) begin
         if (tbl[t].size >= 0) write_order(tbl[t].size);
         send_request(tbl[t].op, tbl[t].row, tbl[t].col, tbl[t].value);
         if (tbl[t].fixed) begin
            elem_type pred;
            pred = expected_q[expected_q.size() - 1];
            if (pred !== tbl[t].ans) report_mismatch("table", pred, tbl[t].ans);
         end
         idle_cycles();
      end

      // Full order 16 once, plus order above range, using all indices.
      write_order(16);
      random_system(16);
      write_order(31);
      send_request(cs_pkg::OP_SOLVE, 0, 0, 0);

      // Random phases, mostly small orders.
      items = 0;
      while (items < 90) begin
         int n;
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
         write_order(n);
         repeat ($urandom_range(1, 3)) begin
            random_system(n);
            items += n * (n + 3) / 2 + 1;
         end
      end

      req.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("tb_cholesky_spd_solver_core passed");
      end else begin
         $display("tb_cholesky_spd_solver_core failed");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/cs_pkg.sv
sv/cs_if.sv
sv/cs_mul.sv
sv/cs_dsq.sv
sv/cs_dpath.sv
sv/cs_ctrl.sv
sv/cholesky_spd_solver_core.sv
dv/tb_cholesky_spd_solver_core.sv
